>>> src/hcid_pkg.sv
// Shared types and constants of the HCI UART packet deframer.
`default_nettype none
package hcid_pkg;

	localparam int unsigned RemW   = 17;
	localparam int unsigned QDepth = 4;
	localparam int unsigned QPtrW  = 2;
	localparam int unsigned QCntW  = 3;

	// parse phase codes
	localparam logic [1:0] PH_HUNT = 2'd0;
	localparam logic [1:0] PH_HEAD = 2'd1;
	localparam logic [1:0] PH_BODY = 2'd2;

	// packet kinds
	localparam logic [2:0] K_EVT = 3'd0;
	localparam logic [2:0] K_ACL = 3'd1;
	localparam logic [2:0] K_DBG = 3'd2;
	localparam logic [2:0] K_RRD = 3'd3;
	localparam logic [2:0] K_RWR = 3'd4;

	// indicator bytes
	localparam logic [7:0] IND_EVT = 8'h04;
	localparam logic [7:0] IND_ACL = 8'h02;
	localparam logic [7:0] IND_DBG = 8'h5a;
	localparam logic [7:0] IND_RRD = 8'h57;
	localparam logic [7:0] IND_RWR = 8'h55;

	localparam logic [7:0] EVT_LE_META    = 8'h3e;
	localparam logic [7:0] LE_META_LEN    = 8'h13;
	localparam logic [7:0] LE_META_BADLEN = 8'h01;
	localparam logic [RemW-1:0] LE_META_REST = 17'h12;

	// output channels
	localparam logic [1:0] CH_EVT = 2'd0;
	localparam logic [1:0] CH_ACL = 2'd1;
	localparam logic [1:0] CH_DBG = 2'd2;
	localparam logic [1:0] CH_RRD = 2'd3;

	// configuration register indexes
	localparam logic CFG_LE_REPAIR = 1'b0;
	localparam logic CFG_VND_FWD   = 1'b1;

	typedef struct packed {
		logic [1:0] channel;
		logic [7:0] data_byte;
		logic       first_of_packet;
		logic       last_of_packet;
		logic       status;
	} res_t;

	typedef struct packed {
		logic [1:0] cnt;
		res_t       r0;
		res_t       r1;
	} push_t;

	typedef struct packed {
		logic le_meta_repair_enable;
		logic vendor_forward_enable;
	} cfg_t;

endpackage
`default_nettype wire

>>> src/hcid_parser.sv
// Header parser: packet state and the results of one received byte.
`default_nettype none
module hcid_parser (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           fire,
	input  wire logic [7:0]     rx_byte,
	input  wire hcid_pkg::cfg_t cfg,
	output hcid_pkg::push_t     push
);

	logic [1:0]                 phase_q, phase_d;
	logic [2:0]                 kind_q, kind_d;
	logic [2:0]                 hidx_q, hidx_d;
	logic [hcid_pkg::RemW-1:0]  rem_q, rem_d;
	logic [7:0]                 lenlo_q, lenlo_d;
	logic                       meta_q, meta_d;
	logic [hcid_pkg::RemW-1:0]  rem_dec;
	logic [15:0]                acl_len;
	logic                       body_last;
	logic                       body_first;
	hcid_pkg::push_t            p;

	function automatic hcid_pkg::res_t mk(input logic [1:0] ch, input logic [7:0] b,
			input logic f, input logic l, input logic st);
		hcid_pkg::res_t r;
		r.channel         = ch;
		r.data_byte       = b;
		r.first_of_packet = f;
		r.last_of_packet  = l;
		r.status          = st;
		return r;
	endfunction

	assign acl_len   = {rx_byte, lenlo_q};
	assign rem_dec   = (rem_q != '0) ? rem_q - 1'b1 : rem_q;
	assign body_last = (rem_dec == '0);
	assign body_first = (hidx_q == 3'd0);

	always_comb begin
		phase_d = phase_q;
		kind_d  = kind_q;
		hidx_d  = hidx_q;
		rem_d   = rem_q;
		lenlo_d = lenlo_q;
		meta_d  = meta_q;
		p.cnt   = 2'd0;
		p.r0    = '0;
		p.r1    = '0;
		case (phase_q)
			hcid_pkg::PH_HEAD: begin
				case (kind_q)
					hcid_pkg::K_EVT: begin
						if (hidx_q == 3'd0) begin
							meta_d = (rx_byte == hcid_pkg::EVT_LE_META);
							p.cnt  = 2'd1;
							p.r0   = mk(hcid_pkg::CH_EVT, rx_byte, 1'b1, 1'b0, 1'b0);
							hidx_d = 3'd1;
						end else if (meta_q && rx_byte == hcid_pkg::LE_META_BADLEN &&
								cfg.le_meta_repair_enable) begin
							// insert the missing length, then pass the byte on as data
							p.cnt   = 2'd2;
							p.r0    = mk(hcid_pkg::CH_EVT, hcid_pkg::LE_META_LEN,
								1'b0, 1'b0, 1'b0);
							p.r1    = mk(hcid_pkg::CH_EVT, hcid_pkg::LE_META_BADLEN,
								1'b0, 1'b0, 1'b0);
							rem_d   = hcid_pkg::LE_META_REST;
							phase_d = hcid_pkg::PH_BODY;
						end else begin
							rem_d   = {{(hcid_pkg::RemW-8){1'b0}}, rx_byte};
							p.cnt   = 2'd1;
							p.r0    = mk(hcid_pkg::CH_EVT, rx_byte, 1'b0,
								rx_byte == 8'd0, 1'b0);
							phase_d = (rx_byte != 8'd0) ? hcid_pkg::PH_BODY
								: hcid_pkg::PH_HUNT;
						end
					end
					hcid_pkg::K_ACL: begin
						p.cnt = 2'd1;
						if (hidx_q < 3'd3) begin
							if (hidx_q == 3'd2)
								lenlo_d = rx_byte;
							p.r0   = mk(hcid_pkg::CH_ACL, rx_byte, hidx_q == 3'd0,
								1'b0, 1'b0);
							hidx_d = hidx_q + 3'd1;
						end else begin
							rem_d   = {{(hcid_pkg::RemW-16){1'b0}}, acl_len};
							p.r0    = mk(hcid_pkg::CH_ACL, rx_byte, 1'b0,
								acl_len == 16'd0, 1'b0);
							phase_d = (acl_len != 16'd0) ? hcid_pkg::PH_BODY
								: hcid_pkg::PH_HUNT;
						end
					end
					hcid_pkg::K_DBG: begin
						rem_d   = {{(hcid_pkg::RemW-8){1'b0}}, rx_byte};
						hidx_d  = 3'd0;
						phase_d = (rx_byte != 8'd0) ? hcid_pkg::PH_BODY
							: hcid_pkg::PH_HUNT;
					end
					hcid_pkg::K_RRD, hcid_pkg::K_RWR: begin
						if (hidx_q == 3'd0)
							rem_d = {{(hcid_pkg::RemW-10){1'b0}}, rx_byte, 2'b00}
								+ hcid_pkg::RemW'(4);
						if (hidx_q >= 3'd2) begin
							hidx_d  = 3'd0;
							phase_d = hcid_pkg::PH_BODY;
						end else begin
							hidx_d = hidx_q + 3'd1;
						end
					end
					default: phase_d = hcid_pkg::PH_HUNT;
				endcase
			end
			hcid_pkg::PH_BODY: begin
				rem_d = rem_dec;
				if (kind_q == hcid_pkg::K_DBG || kind_q == hcid_pkg::K_RRD)
					hidx_d = 3'd1;
				case (kind_q)
					hcid_pkg::K_EVT: begin
						p.cnt = 2'd1;
						p.r0  = mk(hcid_pkg::CH_EVT, rx_byte, 1'b0, body_last, 1'b0);
					end
					hcid_pkg::K_ACL: begin
						p.cnt = 2'd1;
						p.r0  = mk(hcid_pkg::CH_ACL, rx_byte, 1'b0, body_last, 1'b0);
					end
					hcid_pkg::K_DBG: begin
						p.cnt = {1'b0, cfg.vendor_forward_enable};
						p.r0  = mk(hcid_pkg::CH_DBG, rx_byte, body_first, body_last, 1'b0);
					end
					hcid_pkg::K_RRD: begin
						p.cnt = {1'b0, cfg.vendor_forward_enable};
						p.r0  = mk(hcid_pkg::CH_RRD, rx_byte, body_first, body_last, 1'b0);
					end
					default: p.cnt = 2'd0;
				endcase
				if (body_last || kind_q > hcid_pkg::K_RWR)
					phase_d = hcid_pkg::PH_HUNT;
			end
			default: begin
				phase_d = hcid_pkg::PH_HEAD;
				hidx_d  = 3'd0;
				meta_d  = 1'b0;
				case (rx_byte)
					hcid_pkg::IND_EVT: kind_d = hcid_pkg::K_EVT;
					hcid_pkg::IND_ACL: kind_d = hcid_pkg::K_ACL;
					hcid_pkg::IND_DBG: kind_d = hcid_pkg::K_DBG;
					hcid_pkg::IND_RRD: kind_d = hcid_pkg::K_RRD;
					hcid_pkg::IND_RWR: kind_d = hcid_pkg::K_RWR;
					default: begin
						// drop unknown indicator, report it
						phase_d = hcid_pkg::PH_HUNT;
						p.cnt   = 2'd1;
						p.r0    = mk(hcid_pkg::CH_EVT, rx_byte, 1'b0, 1'b0, 1'b1);
					end
				endcase
			end
		endcase
		if (!fire)
			p.cnt = 2'd0;
	end

	assign push = p;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= hcid_pkg::PH_HUNT;
			kind_q  <= hcid_pkg::K_EVT;
			hidx_q  <= 3'd0;
			rem_q   <= '0;
			lenlo_q <= 8'd0;
			meta_q  <= 1'b0;
		end else if (fire) begin
			phase_q <= phase_d;
			kind_q  <= kind_d;
			hidx_q  <= hidx_d;
			rem_q   <= rem_d;
			lenlo_q <= lenlo_d;
			meta_q  <= meta_d;
		end
	end

endmodule
`default_nettype wire

>>> src/hcid_ofifo.sv
// Result queue: takes up to two results a cycle, hands out one.
`default_nettype none
module hcid_ofifo (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire hcid_pkg::push_t push,
	output logic                 room,
	output logic [hcid_pkg::QCntW-1:0] count,
	output logic                 out_valid,
	input  wire logic            out_ready,
	output hcid_pkg::res_t       out_res
);

	hcid_pkg::res_t                  mem_q [hcid_pkg::QDepth];
	logic [hcid_pkg::QPtrW-1:0]      wp_q, rp_q;
	logic [hcid_pkg::QCntW-1:0]      cnt_q;
	logic                            pop;
	logic [hcid_pkg::QPtrW-1:0]      wp1;

	assign wp1       = wp_q + 1'b1;
	assign out_valid = (cnt_q != '0);
	assign out_res   = mem_q[rp_q];
	assign pop       = out_valid && out_ready;
	// room for two more, whatever leaves this cycle
	assign room      = (cnt_q <= hcid_pkg::QCntW'(hcid_pkg::QDepth - 2));
	assign count     = cnt_q;

	always_ff @(posedge clk) begin
		if (push.cnt != 2'd0)
			mem_q[wp_q] <= push.r0;
		if (push.cnt == 2'd2)
			mem_q[wp1] <= push.r1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			wp_q  <= wp_q + push.cnt;
			if (pop)
				rp_q <= rp_q + 1'b1;
			cnt_q <= cnt_q + {1'b0, push.cnt} - {{(hcid_pkg::QCntW-1){1'b0}}, pop};
		end
	end

endmodule
`default_nettype wire

>>> src/hci_uart_packet_deframer_core.sv
// Top level of the HCI UART packet deframer.
// Usage:
//   Feed received UART bytes on the s_ channel, one item per byte in s_tdata.
//   Each byte that opens a packet (event, ACL, vendor debug, register read or
//   write) is stripped; event and ACL bytes and forwarded debug and read
//   bodies come out on m_ with channel, first mark and error status in
//   m_tuser, last mark on m_tlast. An unknown indicator byte yields one item
//   with status set. The cfg channel writes the two enable bits (index 0 LE
//   meta repair, index 1 vendor forwarding); cfg_ready is always high.
// Timing:
//   A byte is taken into an input register and parsed from there when the
//   four-entry result queue has room; its results are written into the queue
//   and shown on m_ from there. One byte per cycle is sustained; a repaired
//   LE meta length makes two results from one byte, which the queue absorbs.
//   The input register and the queue's free space set the rate.
// Reset and stall:
//   Reset empties the queue, returns the parser to hunting for an indicator
//   and sets both enables. When m_tready stays low the queue fills with
//   results and s_tready drops once it lacks room for two; nothing is lost.
`default_nettype none
module hci_uart_packet_deframer_core (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       s_tvalid,
	output logic            s_tready,
	input  wire logic [7:0] s_tdata,   // [7:0] rx_byte
	output logic            m_tvalid,
	input  wire logic       m_tready,
	output logic [7:0]      m_tdata,   // [7:0] data_byte
	output logic            m_tlast,   // last_of_packet
	output logic [3:0]      m_tuser,   // [1:0] channel, [2] first_of_packet, [3] status
	input  wire logic       cfg_valid,
	output logic            cfg_ready,
	input  wire logic       cfg_index,
	input  wire logic       cfg_data
);

	logic                       s1_valid_q;
	logic [7:0]                 byte_s1;
	logic                       room;
	logic                       adv;
	logic [hcid_pkg::QCntW-1:0] qcount;
	hcid_pkg::cfg_t             cfg_q;
	hcid_pkg::push_t            push;
	hcid_pkg::res_t             res;

	assign cfg_ready = 1'b1;
	assign adv       = s1_valid_q && room;
	assign s_tready  = !s1_valid_q || room;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.le_meta_repair_enable <= 1'b1;
			cfg_q.vendor_forward_enable <= 1'b1;
		end else if (cfg_valid) begin
			if (cfg_index == hcid_pkg::CFG_LE_REPAIR)
				cfg_q.le_meta_repair_enable <= cfg_data;
			if (cfg_index == hcid_pkg::CFG_VND_FWD)
				cfg_q.vendor_forward_enable <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			s1_valid_q <= 1'b0;
		else if (s_tready)
			s1_valid_q <= s_tvalid;
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid)
			byte_s1 <= s_tdata;
	end

	hcid_parser u_parser (
		.clk     (clk),
		.arst_n  (arst_n),
		.fire    (adv),
		.rx_byte (byte_s1),
		.cfg     (cfg_q),
		.push    (push)
	);

	hcid_ofifo u_ofifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.room      (room),
		.count     (qcount),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_res   (res)
	);

	assign m_tdata = res.data_byte;
	assign m_tlast = res.last_of_packet;
	assign m_tuser = {res.status, res.first_of_packet, res.channel};

	a_qcount_bound: assert property (@(posedge clk) disable iff (!arst_n)
		qcount <= hcid_pkg::QCntW'(hcid_pkg::QDepth))
		else $error("result queue over capacity");

	a_empty_no_valid: assert property (@(posedge clk) disable iff (!arst_n)
		(qcount == '0) |-> !m_tvalid)
		else $error("output valid with empty queue");

	a_hold_stalled: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_valid_q && !room) |=> (s1_valid_q && $stable(byte_s1)))
		else $error("stalled input byte lost");

	a_push_needs_room: assert property (@(posedge clk) disable iff (!arst_n)
		(push.cnt != 2'd0) |-> room)
		else $error("results pushed without room");

endmodule
`default_nettype wire

>>> tb/sv/deframe_checker.sv
// Checker for the HCI UART deframer: predicts every output item from the accepted bytes.
module deframe_checker (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	input  logic       s_tready,
	input  logic [7:0] s_tdata,
	input  logic       m_tvalid,
	input  logic       m_tready,
	input  logic [7:0] m_tdata,
	input  logic       m_tlast,
	input  logic [3:0] m_tuser,
	input  logic       cfg_valid,
	input  logic       cfg_ready,
	input  logic       cfg_index,
	input  logic       cfg_data,
	output int         errors,
	output int         pending
);
	import hcid_pkg::*;

	logic            repair_en;
	logic            fwd_en;
	logic [1:0]      phase;
	logic [2:0]      kind;
	logic [2:0]      hdr_idx;
	logic [RemW-1:0] remain;
	logic [7:0]      len_lo;
	logic            meta_seen;
	res_t            deframed_q[$];
	res_t            want;

	function automatic void push_out(input logic [1:0] ch, input logic [7:0] b,
			input logic first, input logic last, input logic st);
		res_t r;
		r.channel         = ch;
		r.data_byte       = b;
		r.first_of_packet = first;
		r.last_of_packet  = last;
		r.status          = st;
		deframed_q.push_back(r);
	endfunction

	// advance the parser by one received byte and queue what it forwards
	function automatic void deframe_byte(input logic [7:0] b);
		logic            first;
		logic            last;
		logic [RemW-1:0] len;
		case (phase)
		PH_HEAD: begin
			case (kind)
			K_EVT: begin
				if (hdr_idx == 3'd0) begin
					meta_seen = (b == EVT_LE_META);
					push_out(CH_EVT, b, 1'b1, 1'b0, 1'b0);
					hdr_idx = 3'd1;
				end else if (meta_seen && b == LE_META_BADLEN && repair_en) begin
					// forward the repaired length, then the received byte as a parameter
					push_out(CH_EVT, LE_META_LEN, 1'b0, 1'b0, 1'b0);
					push_out(CH_EVT, LE_META_BADLEN, 1'b0, 1'b0, 1'b0);
					remain = LE_META_REST;
					phase = PH_BODY;
				end else begin
					remain = RemW'(b);
					push_out(CH_EVT, b, 1'b0, b == 8'd0, 1'b0);
					phase = (b != 8'd0) ? PH_BODY : PH_HUNT;
				end
			end
			K_ACL: begin
				if (hdr_idx < 3'd3) begin
					if (hdr_idx == 3'd2)
						len_lo = b;
					push_out(CH_ACL, b, hdr_idx == 3'd0, 1'b0, 1'b0);
					hdr_idx = hdr_idx + 3'd1;
				end else begin
					len = {1'b0, b, len_lo};
					remain = len;
					push_out(CH_ACL, b, 1'b0, len == '0, 1'b0);
					phase = (len != '0) ? PH_BODY : PH_HUNT;
				end
			end
			K_DBG: begin
				remain = RemW'(b);
				hdr_idx = 3'd0;
				phase = (b != 8'd0) ? PH_BODY : PH_HUNT;
			end
			K_RRD, K_RWR: begin
				if (hdr_idx == 3'd0)
					remain = (RemW'(b) << 2) + RemW'(4);
				if (hdr_idx >= 3'd2) begin
					hdr_idx = 3'd0;
					phase = PH_BODY;
				end else begin
					hdr_idx = hdr_idx + 3'd1;
				end
			end
			default: phase = PH_HUNT;
			endcase
		end
		PH_BODY: begin
			if (remain != '0)
				remain = remain - 1'b1;
			last = (remain == '0);
			first = 1'b0;
			// debug and register-read bodies carry their own first mark
			if (kind == K_DBG || kind == K_RRD) begin
				first = (hdr_idx == 3'd0);
				hdr_idx = 3'd1;
			end
			case (kind)
			K_EVT: push_out(CH_EVT, b, 1'b0, last, 1'b0);
			K_ACL: push_out(CH_ACL, b, 1'b0, last, 1'b0);
			K_DBG: if (fwd_en) push_out(CH_DBG, b, first, last, 1'b0);
			K_RRD: if (fwd_en) push_out(CH_RRD, b, first, last, 1'b0);
			default: ;
			endcase
			if (last || kind > K_RWR)
				phase = PH_HUNT;
		end
		default: begin
			phase = PH_HUNT;
			hdr_idx = 3'd0;
			meta_seen = 1'b0;
			case (b)
			IND_EVT: begin kind = K_EVT; phase = PH_HEAD; end
			IND_ACL: begin kind = K_ACL; phase = PH_HEAD; end
			IND_DBG: begin kind = K_DBG; phase = PH_HEAD; end
			IND_RRD: begin kind = K_RRD; phase = PH_HEAD; end
			IND_RWR: begin kind = K_RWR; phase = PH_HEAD; end
			default: push_out(CH_EVT, b, 1'b0, 1'b0, 1'b1);
			endcase
		end
		endcase
	endfunction

	function automatic void check_field(input string name, input int unsigned want_v,
			input int unsigned got_v);
		if (want_v != got_v) begin
			errors++;
			$display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want_v, got_v);
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			repair_en = 1'b1;
			fwd_en = 1'b1;
			phase = PH_HUNT;
			kind = K_EVT;
			hdr_idx = 3'd0;
			remain = '0;
			len_lo = 8'd0;
			meta_seen = 1'b0;
			deframed_q.delete();
			errors = 0;
			pending = 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == CFG_LE_REPAIR)
					repair_en = cfg_data;
				else
					fwd_en = cfg_data;
			end
			if (m_tvalid && m_tready) begin
				if (deframed_q.size() == 0) begin
					errors++;
					$display("%0t: output item mismatch: expected none, actual data %0h user %0h last %b",
						$time, m_tdata, m_tuser, m_tlast);
				end else begin
					want = deframed_q.pop_front();
					check_field("channel", want.channel, m_tuser[1:0]);
					check_field("data_byte", want.data_byte, m_tdata);
					check_field("first_of_packet", want.first_of_packet, m_tuser[2]);
					check_field("last_of_packet", want.last_of_packet, m_tlast);
					check_field("status", want.status, m_tuser[3]);
				end
			end
			if (s_tvalid && s_tready)
				deframe_byte(s_tdata);
			pending = deframed_q.size();
		end
	end

endmodule

>>> tb/sv/tb_top.sv
// Top of the HCI UART deframer testbench: clock, reset, byte stimulus, output stalls, verdict.
module tb_top;
	import hcid_pkg::*;

	logic       clk = 1'b0;
	logic       arst_n;
	logic       s_tvalid;
	logic       s_tready;
	logic [7:0] s_tdata;
	logic       m_tvalid;
	logic       m_tready;
	logic [7:0] m_tdata;
	logic       m_tlast;
	logic [3:0] m_tuser;
	logic       cfg_valid;
	logic       cfg_ready;
	logic       cfg_index;
	logic       cfg_data;
	int         errors;
	int         pending;

	int         sent;
	int         rx_hold;
	logic       tx_burst;
	logic       repair_on;
	logic [7:0] pkt[$];

	hci_uart_packet_deframer_core dut (.*);
	deframe_checker chk (.*);

	always #5 clk = ~clk;

	initial begin
		#5000000;
		$display("Verification failed");
		$finish;
	end

	task automatic put_byte(input logic [7:0] b);
		int n;
		n = tx_burst ? 0 : $urandom_range(0, 19);
		if (n > 0) begin
			s_tvalid <= 1'b0;
			repeat (n) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= b;
		do @(posedge clk); while (!s_tready);
		sent++;
	endtask

	task automatic send_pkt();
		foreach (pkt[i])
			put_byte(pkt[i]);
	endtask

	function automatic void add_fill(input int count);
		repeat (count) pkt.push_back(8'($urandom));
	endfunction

	// mostly well-formed packets with random content, some noise and cut-short packets
	task automatic make_packet();
		int         pick;
		int         len;
		logic [7:0] code;
		pick = $urandom_range(0, 99);
		pkt.delete();
		if (pick < 8) begin
			pkt.push_back(8'($urandom));
		end else if (pick < 40) begin
			code = ($urandom_range(0, 3) == 0) ? EVT_LE_META : 8'($urandom);
			len = ($urandom_range(0, 3) == 0) ? 1 : $urandom_range(0, 12);
			pkt = {IND_EVT, code, 8'(len)};
			if (code == EVT_LE_META && len == 1 && repair_on)
				add_fill(int'(LE_META_REST));
			else
				add_fill(len);
		end else if (pick < 65) begin
			len = ($urandom_range(0, 39) == 0) ? $urandom_range(256, 260) : $urandom_range(0, 10);
			pkt = {IND_ACL, 8'($urandom), 8'($urandom), 8'(len), 8'(len >> 8)};
			add_fill(len);
		end else if (pick < 80) begin
			len = $urandom_range(0, 10);
			pkt = {IND_DBG, 8'(len)};
			add_fill(len);
		end else begin
			len = ($urandom_range(0, 19) == 0) ? $urandom_range(4, 16) : $urandom_range(0, 3);
			pkt = {(pick < 92) ? IND_RRD : IND_RWR, 8'(len), 8'($urandom), 8'($urandom)};
			add_fill(len * 4 + 4);
		end
		if (pkt.size() > 2 && $urandom_range(0, 24) == 0)
			repeat ($urandom_range(1, pkt.size() - 2)) void'(pkt.pop_back());
	endtask

	task automatic set_config(input logic repair, input logic fwd);
		cfg_valid <= 1'b1;
		cfg_index <= CFG_LE_REPAIR;
		cfg_data <= repair;
		do @(posedge clk); while (!cfg_ready);
		cfg_index <= CFG_VND_FWD;
		cfg_data <= fwd;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	// hold the input until every predicted item is out, then let the pipeline empty
	task automatic settle();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (pending != 0);
		repeat (8) @(posedge clk);
	endtask

	initial begin : stim
		int         target;
		int         pressure_end;
		logic [1:0] cfg_plan [4];
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = 8'd0;
		cfg_valid = 1'b0;
		cfg_index = CFG_LE_REPAIR;
		cfg_data = 1'b0;
		sent = 0;
		rx_hold = 0;
		tx_burst = 1'b0;
		repair_on = 1'b1;
		cfg_plan = '{2'b00, 2'b10, 2'b01, 2'b11};
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// unknown indicators, empty and short packets of each kind, LE meta repair
		pkt = {8'hff, 8'h00};
		send_pkt();
		pkt = {IND_EVT, 8'h0e, 8'h00};
		send_pkt();
		pkt = {IND_EVT, EVT_LE_META, LE_META_BADLEN};
		add_fill(int'(LE_META_REST));
		send_pkt();
		pkt = {IND_EVT, 8'hff, 8'h02, 8'haa, 8'h55};
		send_pkt();
		pkt = {IND_ACL, 8'hff, 8'hff, 8'h00, 8'h00};
		send_pkt();
		pkt = {IND_ACL, 8'h00, 8'h00, 8'h01, 8'h00, 8'h80};
		send_pkt();
		pkt = {IND_DBG, 8'h00};
		send_pkt();
		pkt = {IND_DBG, 8'h02, 8'h41, 8'h7f};
		send_pkt();
		pkt = {IND_RRD, 8'h00, 8'h11, 8'h22};
		add_fill(4);
		send_pkt();
		pkt = {IND_RWR, 8'h00, 8'h33, 8'h44};
		add_fill(4);
		send_pkt();
		settle();

		for (int p = 0; p < 4; p++) begin
			set_config(cfg_plan[p][1], cfg_plan[p][0]);
			repair_on = cfg_plan[p][1];
			target = sent + 120;
			pressure_end = 0;
			if (p == 2) begin
				// stall the output for a long stretch while bytes keep coming
				rx_hold = 300;
				pressure_end = sent + 60;
			end
			while (sent < target) begin
				tx_burst = (sent < pressure_end) || ($urandom_range(0, 3) == 0);
				make_packet();
				send_pkt();
			end
			settle();
		end

		if (errors == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

	initial begin : drain
		int   n;
		logic rx_burst;
		m_tready = 1'b0;
		rx_burst = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			if ($urandom_range(0, 15) == 0)
				rx_burst = ~rx_burst;
			if (rx_hold > 0) begin
				n = rx_hold;
				rx_hold = 0;
			end else begin
				n = rx_burst ? 0 : $urandom_range(0, 19);
			end
			if (n > 0) begin
				m_tready <= 1'b0;
				repeat (n) @(posedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
		end
	end

endmodule
